@@ hw/rtl/bole_pkg.sv @@
package bole_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int POS_W         = 4;
    localparam int COUNT_W       = 5;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_POP_FRONT  = 3'd1,
        OP_PUSH_TAIL  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CONTAINS   = 3'd4,
        OP_INSERT     = 3'd5,
        OP_READ_NTH   = 3'd6,
        OP_REMOVE     = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // What every cell does in one update. The index it applies to is sent alongside.
    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_OPEN  = 2'd1,
        CELL_WRITE = 2'd2,
        CELL_CLOSE = 2'd3
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode         mode;
        logic signed [WORD_W-1:0] value;
    } t_cell_cmd;

    typedef struct packed {
        t_opcode                  opcode;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] result_value;
        logic                     found;
        t_status                  status;
        logic [COUNT_W-1:0]       entry_count;
    } t_rsp;

endpackage

@@ hw/rtl/bounded_ordered_list_engine.sv @@
// Bounded ordered list engine: an ordered list of up to DEPTH signed 32-bit words held
// in a row of cells, each cell one word, that shift toward their neighbors all at once.
// Each request carries an opcode (push or pop at either end, contains, insert at,
// read nth, remove at), a position and a value, and gives exactly one response with the
// popped or read word, a found flag, a status (ok, empty, full, out of range) and the
// entry count after the request. A request is registered at acceptance and executed once
// the output register is free or being emptied, when every cell updates at once and the
// response is written into the output register. One request is taken per cycle as long
// as responses are taken, the rate being set by the cell update and the single output
// register. No clearing pass is needed after reset.
module bounded_ordered_list_engine #(
    parameter int DEPTH = bole_pkg::DEPTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  bole_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output bole_pkg::t_rsp o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    // Width in which positions and the length are compared.
    localparam int EW = (CW > bole_pkg::POS_W) ? CW : bole_pkg::POS_W;

    // Request stage: the accepted request waits here for its execute cycle.
    logic           r_busy;
    bole_pkg::t_req r_req;

    // Number of words in the list.
    logic [CW-1:0] r_len;
    logic [CW-1:0] n_len;

    // Response register.
    logic           r_rsp_valid;
    bole_pkg::t_rsp r_rsp;

    logic advance;
    logic accept;

    assign advance     = r_busy && (!r_rsp_valid || i_rsp_ready);
    assign o_req_ready = !r_busy || advance;
    assign accept      = i_req_valid && o_req_ready;

    // Decode of the waiting request against the current length.
    bole_pkg::t_cell_mode dec_mode;
    bole_pkg::t_cell_cmd  cell_cmd;
    bole_pkg::t_status    dec_status;
    logic [AW-1:0]        dec_at;
    logic                 dec_take;
    logic                 dec_search;
    logic [EW-1:0]        pos_e;
    logic [EW-1:0]        len_e;
    logic                 is_full;
    logic                 is_empty;
    logic [CW-1:0]        last_idx;

    always_comb begin
        pos_e      = EW'(r_req.position);
        len_e      = EW'(r_len);
        is_full    = (r_len == CW'(DEPTH));
        is_empty   = (r_len == '0);
        last_idx   = r_len - CW'(1);
        dec_mode   = bole_pkg::CELL_HOLD;
        dec_status = bole_pkg::ST_OK;
        dec_at     = '0;
        dec_take   = 1'b0;
        dec_search = 1'b0;
        n_len      = r_len;
        case (r_req.opcode)
            bole_pkg::OP_PUSH_FRONT: begin
                if (is_full) begin
                    dec_status = bole_pkg::ST_FULL;
                end else begin
                    dec_mode = bole_pkg::CELL_OPEN;
                    n_len    = r_len + CW'(1);
                end
            end
            bole_pkg::OP_POP_FRONT: begin
                if (is_empty) begin
                    dec_status = bole_pkg::ST_EMPTY;
                end else begin
                    dec_mode = bole_pkg::CELL_CLOSE;
                    dec_take = 1'b1;
                    n_len    = last_idx;
                end
            end
            bole_pkg::OP_PUSH_TAIL: begin
                if (is_full) begin
                    dec_status = bole_pkg::ST_FULL;
                end else begin
                    // The length is below DEPTH here, so it fits an index.
                    dec_mode = bole_pkg::CELL_WRITE;
                    dec_at   = AW'(r_len);
                    n_len    = r_len + CW'(1);
                end
            end
            bole_pkg::OP_POP_BACK: begin
                if (is_empty) begin
                    dec_status = bole_pkg::ST_EMPTY;
                end else begin
                    // Popping the only word leaves the list fully empty.
                    dec_mode = bole_pkg::CELL_CLOSE;
                    dec_at   = AW'(last_idx);
                    dec_take = 1'b1;
                    n_len    = last_idx;
                end
            end
            bole_pkg::OP_CONTAINS: begin
                dec_search = 1'b1;
            end
            bole_pkg::OP_INSERT: begin
                // The range check comes before the full check.
                if (pos_e > len_e) begin
                    dec_status = bole_pkg::ST_RANGE;
                end else if (is_full) begin
                    dec_status = bole_pkg::ST_FULL;
                end else begin
                    dec_mode = bole_pkg::CELL_OPEN;
                    dec_at   = AW'(pos_e);
                    n_len    = r_len + CW'(1);
                end
            end
            bole_pkg::OP_READ_NTH: begin
                if (pos_e >= len_e) begin
                    dec_status = bole_pkg::ST_RANGE;
                end else begin
                    dec_at   = AW'(pos_e);
                    dec_take = 1'b1;
                end
            end
            bole_pkg::OP_REMOVE: begin
                if (pos_e >= len_e) begin
                    dec_status = bole_pkg::ST_RANGE;
                end else begin
                    dec_mode = bole_pkg::CELL_CLOSE;
                    dec_at   = AW'(pos_e);
                    dec_take = 1'b1;
                    n_len    = last_idx;
                end
            end
            default: begin
                dec_mode = bole_pkg::CELL_HOLD;
            end
        endcase
    end

    // Cells change only in the cycle that the request executes.
    assign cell_cmd.mode  = advance ? dec_mode : bole_pkg::CELL_HOLD;
    assign cell_cmd.value = r_req.value;

    logic signed [bole_pkg::WORD_W-1:0] cell_word [DEPTH];
    logic signed [bole_pkg::WORD_W-1:0] cell_pick [DEPTH];
    logic [DEPTH-1:0]                   cell_match;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [bole_pkg::WORD_W-1:0] left_word;
        logic signed [bole_pkg::WORD_W-1:0] right_word;

        // The ends of the row feed back their own word; the first cell never selects it, and the last keeps its word.
        if (g == 0) begin : g_first
            assign left_word = cell_word[g];
        end else begin : g_inner_left
            assign left_word = cell_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_word = cell_word[g];
        end else begin : g_inner_right
            assign right_word = cell_word[g+1];
        end

        bole_cell #(
            .INDEX (g),
            .AW    (AW),
            .CW    (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cell_cmd),
            .i_at    (dec_at),
            .i_len   (r_len),
            .i_left  (left_word),
            .i_right (right_word),
            .o_word  (cell_word[g]),
            .o_match (cell_match[g]),
            .o_pick  (cell_pick[g])
        );
    end

    // Each cell drives its word only when it is the selected one, so an OR collects it.
    logic signed [bole_pkg::WORD_W-1:0] picked;

    always_comb begin
        picked = '0;
        for (int k = 0; k < DEPTH; k++) begin
            picked = picked | cell_pick[k];
        end
    end

    bole_pkg::t_rsp n_rsp;

    always_comb begin
        n_rsp.result_value = dec_take ? picked : '0;
        n_rsp.found        = dec_search && (|cell_match);
        n_rsp.status       = dec_status;
        n_rsp.entry_count  = bole_pkg::COUNT_W'(n_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_len       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (advance) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_len       <= n_len;
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (advance) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // The list never holds more words than there are cells.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CW'(DEPTH))
        else $error("list length exceeds the number of cells");

    // The reported count matches the length that the cells now hold.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (o_rsp.entry_count == bole_pkg::COUNT_W'(r_len)))
        else $error("response count differs from list length");

    // A request that fails leaves the list length alone.
    a_fail_keeps_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (dec_status != bole_pkg::ST_OK)) |=> (r_len == $past(r_len)))
        else $error("failed request changed the list length");

    // A waiting response is only dropped after the consumer has taken it.
    a_rsp_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_rsp_valid) |-> $past(i_rsp_ready))
        else $error("response lost before it was taken");

endmodule

@@ hw/rtl/bole_cell.sv @@
module bole_cell #(
    parameter int INDEX = 0,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                              i_clk,
    input  bole_pkg::t_cell_cmd               i_cmd,
    input  logic [AW-1:0]                     i_at,
    input  logic [CW-1:0]                     i_len,
    input  logic signed [bole_pkg::WORD_W-1:0] i_left,
    input  logic signed [bole_pkg::WORD_W-1:0] i_right,
    output logic signed [bole_pkg::WORD_W-1:0] o_word,
    output logic                              o_match,
    output logic signed [bole_pkg::WORD_W-1:0] o_pick
);

    localparam logic [AW-1:0] IDX     = AW'(INDEX);
    localparam logic [CW-1:0] IDX_LEN = CW'(INDEX);

    logic signed [bole_pkg::WORD_W-1:0] r_word;
    logic signed [bole_pkg::WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        case (i_cmd.mode)
            bole_pkg::CELL_OPEN: begin
                if (IDX > i_at) begin
                    n_word = i_left;
                end else if (IDX == i_at) begin
                    n_word = i_cmd.value;
                end
            end
            bole_pkg::CELL_WRITE: begin
                if (IDX == i_at) begin
                    n_word = i_cmd.value;
                end
            end
            bole_pkg::CELL_CLOSE: begin
                if (IDX >= i_at) begin
                    n_word = i_right;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word  = r_word;
    // Only occupied cells take part in a search.
    assign o_match = (IDX_LEN < i_len) && (r_word == i_cmd.value);
    assign o_pick  = (IDX == i_at) ? r_word : '0;

endmodule
